FILE: rtl/two_switch_min_deviation_scorer_defines.svh
// ----------------------------------------------------------------------------
// Two-switch minimum deviation scorer: assertion macros
// Shared assertion shorthands for the checker files of this block.
// ----------------------------------------------------------------------------
`ifndef TWO_SWITCH_MIN_DEVIATION_SCORER_DEFINES_SVH
`define TWO_SWITCH_MIN_DEVIATION_SCORER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TSMD_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define TSMD_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tsmd_pkg.sv
// ----------------------------------------------------------------------------
// Two-switch minimum deviation scorer: package
// Widths, codes, the item and result records and the saturating add.
// ----------------------------------------------------------------------------
package tsmd_pkg;

  localparam int MAX_PERIODS = 16;
  localparam int PIDX_W      = $clog2(MAX_PERIODS);
  localparam int VAL_W       = 12;
  localparam int DEV_W       = 12;
  localparam int COST_W      = 16;
  localparam int PER_W       = 4;
  localparam int SW_W        = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [SW_W-1:0] SW_STAY = 2'd0;
  localparam logic [SW_W-1:0] SW_ONE  = 2'd1;
  localparam logic [SW_W-1:0] SW_TWO  = 2'd2;

  // one period after the front stage: both deviations and the end mark
  typedef struct packed {
    logic [DEV_W-1:0] dev_a;
    logic [DEV_W-1:0] dev_b;
    logic             last;
  } tsmd_item_t;

  // packed so that total_deviation sits in the low bits
  typedef struct packed {
    logic [PER_W-1:0]  return_period;
    logic [PER_W-1:0]  leave_period;
    logic [SW_W-1:0]   switches_used;
    logic [COST_W-1:0] total_deviation;
  } tsmd_result_t;

  localparam int RES_W = $bits(tsmd_result_t);

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] x,
                                                input logic [DEV_W-1:0]  d);
    logic [COST_W:0] s;
    s = {1'b0, x} + (COST_W + 1)'(d);
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

endpackage

FILE: rtl/two_switch_min_deviation_scorer.sv
// ----------------------------------------------------------------------------
// Two-switch minimum deviation scorer: top level
// Streams period pairs in and reports the best stay / leave / return plan.
// ----------------------------------------------------------------------------
// Takes one period per clock (value_a, value_b, tlast on the final period)
// while no unread result blocks a final period. The front stage registers
// both absolute deviations from target_value; the core then updates the three
// plan costs and registers the plan once the final period leaves the front
// register. A series ends on tlast or after 16 periods, whichever comes first.
// Write target_value only while the block is idle.
// ----------------------------------------------------------------------------
module two_switch_min_deviation_scorer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsmd_pkg::VAL_W-1:0]        cfg_data,   // target_value
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tsmd_pkg::IN_TDATA_W-1:0]   in_tdata,   // value_a, value_b
  input  logic                              in_tlast,   // period_last
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // total_deviation, switches_used, leave_period, return_period, zero pad
  output logic [tsmd_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import tsmd_pkg::*;

  logic         item_valid, item_ready;
  tsmd_item_t   item;
  tsmd_result_t res;

  assign cfg_ready = 1'b1;

  tsmd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  tsmd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .res_valid  (out_tvalid),
    .res        (res),
    .res_ready  (out_tready)
  );

  assign out_tdata = {(OUT_TDATA_W - RES_W)'(0), res};

endmodule

FILE: rtl/tsmd_front.sv
// ----------------------------------------------------------------------------
// Two-switch minimum deviation scorer: front stage
// Holds the target register and registers both absolute deviations of a period.
// ----------------------------------------------------------------------------
module tsmd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [tsmd_pkg::VAL_W-1:0]   cfg_data,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tsmd_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                         in_tlast,
  output logic                         item_valid,
  output tsmd_pkg::tsmd_item_t         item,
  input  logic                         item_ready
);
  import tsmd_pkg::*;

  logic [VAL_W-1:0] target_r;
  logic             v_r;
  tsmd_item_t       item_r;
  tsmd_item_t       item_nxt;

  function automatic logic [DEV_W-1:0] abs_dev(input logic [VAL_W-1:0] v,
                                               input logic [VAL_W-1:0] t);
    logic signed [VAL_W:0] d;
    d = $signed({v[VAL_W-1], v}) - $signed({t[VAL_W-1], t});
    return d[VAL_W] ? DEV_W'(-d) : DEV_W'(d);
  endfunction

  assign in_tready = !v_r || item_ready;

  always_comb begin
    item_nxt.dev_a = abs_dev(in_tdata[VAL_W-1:0], target_r);
    item_nxt.dev_b = abs_dev(in_tdata[2*VAL_W-1:VAL_W], target_r);
    item_nxt.last  = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= VAL_W'(700);
      v_r      <= 1'b0;
    end else begin
      if (cfg_valid) target_r <= cfg_data;
      if (in_tready) v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) item_r <= item_nxt;
  end

  assign item_valid = v_r;
  assign item       = item_r;

endmodule

FILE: rtl/tsmd_core.sv
// ----------------------------------------------------------------------------
// Two-switch minimum deviation scorer: accumulator core
// Updates the three plan costs per period and registers the best plan at the end.
// ----------------------------------------------------------------------------
module tsmd_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_valid,
  input  tsmd_pkg::tsmd_item_t     item,
  output logic                     item_ready,
  output logic                     res_valid,
  output tsmd_pkg::tsmd_result_t   res,
  input  logic                     res_ready
);
  import tsmd_pkg::*;

  logic [COST_W-1:0] cost_stay_r, cost_away_r, cost_back_r;
  logic [COST_W-1:0] cost_stay_nxt, cost_away_nxt, cost_back_nxt;
  logic              away_valid_r, back_valid_r, back_valid_nxt;
  logic [PIDX_W-1:0] away_leave_r, back_leave_r, back_return_r, idx_r;
  logic [PIDX_W-1:0] away_leave_nxt, back_leave_nxt, back_return_nxt;
  logic              away_keep, back_keep, pick_back, last_eff, step;
  logic              out_v_r;
  tsmd_result_t      res_r, res_nxt;

  assign last_eff   = item.last || (idx_r == PIDX_W'(MAX_PERIODS - 1));
  assign item_ready = !last_eff || !out_v_r || res_ready;
  assign step       = item_valid && item_ready;

  always_comb begin
    cost_stay_nxt = sat_add(cost_stay_r, item.dev_a);

    // stay in B unless leaving A now is strictly cheaper
    away_keep = away_valid_r && (cost_away_r <= cost_stay_r);
    if (away_keep) begin
      cost_away_nxt  = sat_add(cost_away_r, item.dev_b);
      away_leave_nxt = away_leave_r;
    end else begin
      cost_away_nxt  = sat_add(cost_stay_r, item.dev_b);
      away_leave_nxt = idx_r;
    end

    back_keep = back_valid_r && (!away_valid_r || cost_back_r < cost_away_r ||
                (cost_back_r == cost_away_r && back_leave_r <= away_leave_r));
    cost_back_nxt   = cost_back_r;
    back_leave_nxt  = back_leave_r;
    back_return_nxt = back_return_r;
    if (back_keep) begin
      cost_back_nxt = sat_add(cost_back_r, item.dev_a);
    end else if (away_valid_r) begin
      cost_back_nxt   = sat_add(cost_away_r, item.dev_a);
      back_leave_nxt  = away_leave_r;
      back_return_nxt = idx_r;
    end
    back_valid_nxt = back_valid_r || away_valid_r;

    // final pick over the updated costs; stay wins every tie
    pick_back = back_valid_nxt && (cost_back_nxt < cost_away_nxt ||
                (cost_back_nxt == cost_away_nxt && back_leave_nxt < away_leave_nxt));
    if (cost_stay_nxt <= (pick_back ? cost_back_nxt : cost_away_nxt)) begin
      res_nxt.total_deviation = cost_stay_nxt;
      res_nxt.switches_used   = SW_STAY;
      res_nxt.leave_period    = '0;
      res_nxt.return_period   = '0;
    end else if (pick_back) begin
      res_nxt.total_deviation = cost_back_nxt;
      res_nxt.switches_used   = SW_TWO;
      res_nxt.leave_period    = PER_W'(back_leave_nxt);
      res_nxt.return_period   = PER_W'(back_return_nxt);
    end else begin
      res_nxt.total_deviation = cost_away_nxt;
      res_nxt.switches_used   = SW_ONE;
      res_nxt.leave_period    = PER_W'(away_leave_nxt);
      res_nxt.return_period   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_stay_r   <= '0;
      cost_away_r   <= '0;
      cost_back_r   <= '0;
      away_valid_r  <= 1'b0;
      back_valid_r  <= 1'b0;
      away_leave_r  <= '0;
      back_leave_r  <= '0;
      back_return_r <= '0;
      idx_r         <= '0;
      out_v_r       <= 1'b0;
    end else begin
      if (step && last_eff) begin
        cost_stay_r   <= '0;
        cost_away_r   <= '0;
        cost_back_r   <= '0;
        away_valid_r  <= 1'b0;
        back_valid_r  <= 1'b0;
        away_leave_r  <= '0;
        back_leave_r  <= '0;
        back_return_r <= '0;
        idx_r         <= '0;
      end else if (step) begin
        cost_stay_r   <= cost_stay_nxt;
        cost_away_r   <= cost_away_nxt;
        cost_back_r   <= cost_back_nxt;
        away_valid_r  <= 1'b1;
        back_valid_r  <= back_valid_nxt;
        away_leave_r  <= away_leave_nxt;
        back_leave_r  <= back_leave_nxt;
        back_return_r <= back_return_nxt;
        idx_r         <= idx_r + 1'b1;
      end
      if (step && last_eff) out_v_r <= 1'b1;
      else if (res_ready)   out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last_eff) res_r <= res_nxt;
  end

  assign res_valid = out_v_r;
  assign res       = res_r;

endmodule

FILE: rtl/tsmd_checker.sv
// ----------------------------------------------------------------------------
// Two-switch minimum deviation scorer: port checker
// Watches the result port for consistent plan reports.
// ----------------------------------------------------------------------------
`include "two_switch_min_deviation_scorer_defines.svh"

module tsmd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tsmd_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tsmd_pkg::*;

  `TSMD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `TSMD_ASSERT_NOW(a_sw_code, out_tvalid, out_tdata[17:16] <= SW_TWO, "bad switch count")
  `TSMD_ASSERT_NOW(a_stay_periods, out_tvalid && out_tdata[17:16] == SW_STAY, out_tdata[25:18] == 8'd0, "stay plan reports periods")
  `TSMD_ASSERT_NOW(a_one_return, out_tvalid && out_tdata[17:16] == SW_ONE, out_tdata[25:22] == 4'd0, "one-switch plan reports return")

endmodule

bind two_switch_min_deviation_scorer tsmd_checker u_tsmd_checker (.*);

FILE: verif/deviation_plan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-switch minimum deviation scorer: plan checker
// Tracks the stay / away / back plan costs for each accepted period, predicts
// the plan reported at the end of each series and compares it field by field
// with every result accepted on the output stream.
// ----------------------------------------------------------------------------
module deviation_plan_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tsmd_pkg::VAL_W-1:0]       cfg_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tsmd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tsmd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                               mismatch_count,
  output int                               plans_pending
);
  import tsmd_pkg::*;

  logic signed [VAL_W-1:0] target_value;
  logic [COST_W-1:0]       cost_in_a, cost_in_b, cost_back_a;
  logic                    in_b_seen, back_seen;
  logic [PER_W-1:0]        b_leave, back_leave, back_ret, period_no;
  tsmd_result_t            expected_plans[$];
  tsmd_result_t            want, seen;

  function automatic logic [DEV_W-1:0] deviation(input logic signed [VAL_W-1:0] v,
                                                 input logic signed [VAL_W-1:0] aim);
    int d;
    d = int'(v) - int'(aim);
    return DEV_W'(d < 0 ? -d : d);
  endfunction

  function automatic logic [COST_W-1:0] add_clamped(input logic [COST_W-1:0] c,
                                                    input logic [DEV_W-1:0]  d);
    int unsigned s;
    s = c + d;
    if (s > 32'hFFFF) s = 32'hFFFF;
    return s[COST_W-1:0];
  endfunction

  task automatic clear_series();
    cost_in_a   = '0;
    cost_in_b   = '0;
    cost_back_a = '0;
    in_b_seen   = 1'b0;
    back_seen   = 1'b0;
    b_leave     = '0;
    back_leave  = '0;
    back_ret    = '0;
    period_no   = '0;
  endtask

  task automatic score_period(input logic [IN_TDATA_W-1:0] data, input logic last);
    logic [DEV_W-1:0]  da, db;
    logic [COST_W-1:0] n_a, n_b, n_back;
    logic [PER_W-1:0]  idx, n_bl, n_backl, n_backr;
    logic              n_back_seen;
    tsmd_result_t      plan;
    da          = deviation(data[VAL_W-1:0], target_value);
    db          = deviation(data[2*VAL_W-1:VAL_W], target_value);
    idx         = period_no;
    n_a         = add_clamped(cost_in_a, da);
    n_back      = cost_back_a;
    n_backl     = back_leave;
    n_backr     = back_ret;
    n_back_seen = back_seen || in_b_seen;

    // staying in B keeps the earlier departure unless leaving now is cheaper
    if (in_b_seen && cost_in_b <= cost_in_a) begin
      n_b  = add_clamped(cost_in_b, db);
      n_bl = b_leave;
    end else begin
      n_b  = add_clamped(cost_in_a, db);
      n_bl = idx;
    end

    if (back_seen && (!in_b_seen || cost_back_a < cost_in_b ||
                      (cost_back_a == cost_in_b && back_leave <= b_leave))) begin
      n_back = add_clamped(cost_back_a, da);
    end else if (in_b_seen) begin
      n_back  = add_clamped(cost_in_b, da);
      n_backl = b_leave;
      n_backr = idx;
    end

    cost_in_a   = n_a;
    cost_in_b   = n_b;
    b_leave     = n_bl;
    in_b_seen   = 1'b1;
    cost_back_a = n_back;
    back_leave  = n_backl;
    back_ret    = n_backr;
    back_seen   = n_back_seen;

    // a full-length series closes even without the end mark
    if (!last && idx < PER_W'(MAX_PERIODS - 1)) begin
      period_no = idx + 1'b1;
      return;
    end

    if (back_seen && (cost_back_a < cost_in_b ||
                      (cost_back_a == cost_in_b && back_leave < b_leave))) begin
      plan.total_deviation = cost_back_a;
      plan.switches_used   = SW_TWO;
      plan.leave_period    = back_leave;
      plan.return_period   = back_ret;
    end else begin
      plan.total_deviation = cost_in_b;
      plan.switches_used   = SW_ONE;
      plan.leave_period    = b_leave;
      plan.return_period   = '0;
    end
    if (cost_in_a <= plan.total_deviation) begin
      plan.total_deviation = cost_in_a;
      plan.switches_used   = SW_STAY;
      plan.leave_period    = '0;
      plan.return_period   = '0;
    end
    expected_plans.insert(expected_plans.size(), plan);
    clear_series();
  endtask

  task automatic compare_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t plan mismatch on %s: expected %0d, got %0d",
               $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      target_value = VAL_W'(700);
      clear_series();
      expected_plans.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_plans.size() == 0) begin
          $display("%0t unexpected plan reported: expected none, got %h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = expected_plans.pop_front();
          seen = tsmd_result_t'(out_tdata[RES_W-1:0]);
          compare_field("total_deviation", want.total_deviation, seen.total_deviation);
          compare_field("switches_used", want.switches_used, seen.switches_used);
          compare_field("leave_period", want.leave_period, seen.leave_period);
          compare_field("return_period", want.return_period, seen.return_period);
        end
      end
      if (cfg_valid && cfg_ready) target_value = cfg_data;
      if (in_tvalid && in_tready) score_period(in_tdata, in_tlast);
    end
    plans_pending = expected_plans.size();
  end

endmodule

FILE: verif/two_switch_min_deviation_scorer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-switch minimum deviation scorer: testbench
// Streams directed and random period series under several targets and
// idle/stall patterns, including a long output hold-off; the plan checker
// predicts and compares every reported plan.
// ----------------------------------------------------------------------------
module two_switch_min_deviation_scorer_tb;
  import tsmd_pkg::*;

  localparam int VALUE_MIN       = -999;
  localparam int VALUE_MAX       = 1499;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_PERIODS  = 500;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [VAL_W-1:0]       cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int snd_idle_pct  = 0;
  int rcv_idle_pct  = 0;
  bit hold_off_req  = 1'b0;
  int periods_sent  = 0;
  int mismatch_count;
  int plans_pending;

  always #2 clk = ~clk;

  two_switch_min_deviation_scorer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  deviation_plan_checker plan_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .plans_pending  (plans_pending)
  );

  // result sink: random stalls, or a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send_period(input int a, input int b, input bit last);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {VAL_W'(b), VAL_W'(a)};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    periods_sent++;
  endtask

  function automatic int value_near(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < VALUE_MIN) v = VALUE_MIN;
    if (v > VALUE_MAX) v = VALUE_MAX;
    return v;
  endfunction

  task automatic send_series(input int len, input bit end_mark, input int aim);
    int shape, w0, w1, a, b;
    shape = $urandom_range(0, 2);
    w0    = $urandom_range(0, len - 1);
    w1    = $urandom_range(w0, len);
    for (int k = 0; k < len; k++) begin
      case (shape)
        0: begin
          a = value_near(250, 1249);
          b = value_near(250, 1249);
        end
        // everything within a count of the target: plenty of cost ties
        1: begin
          a = value_near(aim, 1);
          b = value_near(aim, 1);
        end
        // B is the better series inside a window, A outside it
        default: begin
          if (k >= w0 && k < w1) begin
            a = value_near(aim, 900);
            b = value_near(aim, 15);
          end else begin
            a = value_near(aim, 15);
            b = value_near(aim, 900);
          end
        end
      endcase
      send_period(a, b, end_mark && k == len - 1);
    end
  endtask

  task automatic random_phase(input int aim, input int quota);
    int first, len, r;
    bit end_mark;
    first = periods_sent;
    while (periods_sent - first < quota) begin
      r        = $urandom_range(0, 15);
      end_mark = 1'b1;
      if (r < 2) begin
        len = 1;
      end else if (r < 4) begin
        // runs past the period limit, so the block splits it
        len = $urandom_range(MAX_PERIODS + 1, MAX_PERIODS + 8);
      end else if (r == 4) begin
        len      = MAX_PERIODS;
        end_mark = 1'b0;
      end else begin
        len = $urandom_range(2, MAX_PERIODS);
      end
      send_series(len, end_mark, aim);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    wait (plans_pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_target(input int t);
    cfg_valid <= 1'b1;
    cfg_data  <= VAL_W'(t);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int aim;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed series at the reset target of 700
    send_period(VALUE_MIN, VALUE_MAX, 1'b1);
    send_period(VALUE_MAX, VALUE_MIN, 1'b1);
    send_period(700, 700, 1'b1);
    send_period(700, 0, 1'b0);
    send_period(0, 700, 1'b0);
    send_period(700, 0, 1'b1);
    // one switch and two switches cost the same here
    send_period(700, 0, 1'b0);
    send_period(0, 700, 1'b0);
    send_period(700, 700, 1'b1);
    // full-length series with no end mark
    for (int k = 0; k < MAX_PERIODS; k++)
      send_period(k < 8 ? VALUE_MAX : 700, k < 8 ? 700 : VALUE_MIN, 1'b0);
    settle();

    aim = VALUE_MIN;
    write_target(aim);
    snd_idle_pct = 29;
    rcv_idle_pct = 46;
    random_phase(aim, RANDOM_PERIODS);
    settle();

    aim = VALUE_MAX;
    write_target(aim);
    snd_idle_pct = 46;
    rcv_idle_pct = 29;
    random_phase(aim, RANDOM_PERIODS);
    settle();

    aim = int'($urandom_range(0, VALUE_MAX - VALUE_MIN)) + VALUE_MIN;
    write_target(aim);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_phase(aim, RANDOM_PERIODS);
    settle();

    // output held off while short series keep coming: input must back up
    aim = 700;
    write_target(aim);
    hold_off_req = 1'b1;
    repeat (40) send_series($urandom_range(1, 2), 1'b1, aim);
    settle();

    if (mismatch_count == 0)
      $display("[two_switch_min_deviation_scorer] OK");
    else
      $display("[two_switch_min_deviation_scorer] ERROR");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[two_switch_min_deviation_scorer] ERROR");
    $finish;
  end

endmodule
